/* rtl/ssiq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssiq_pkg: shared types and constants of the sorted insert queue
// Field widths, parameter defaults, op codes and the per-cycle cell command.
// ----------------------------------------------------------------------------
package ssiq_pkg;

  localparam int DEPTH_DEFAULT       = 256;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  localparam int SYMBOL_W   = 8;
  localparam int IN_COUNT_W = 32;
  localparam int FILL_W     = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // broadcast to every cell; at most one bit is set in a cycle
  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } ssiq_cmd_t;

endpackage

/* rtl/stable_sorted_insert_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_insert_queue_unit: frequency-ordered symbol queue
// Keeps up to DEPTH (symbol, count) entries in ascending count order, ties
// in arrival order; supports insert, pop of the smallest entry and clear.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. busy
//   stays low, so a request may be issued in every cycle: the row of slot
//   cells compares all entries with the new count in parallel and shifts at
//   the edge that takes the request, so the rate is one request per cycle.
//   op selects insert (symbol, count), pop or clear. Each request gives one
//   result in the cycle after it is taken: done is high for exactly one cycle with
//   head_symbol/head_count/head_valid (pop only, zero otherwise), fill (the
//   entry count after the request) and overflow (insert dropped, queue full).
//   A zero count insert leaves the queue unchanged. Op code 3 does nothing.
//   The receiver cannot stall; results must be taken in the done cycle.
//   Synchronous reset empties the queue at once; no clearing pass is needed,
//   since each slot carries its own valid flag.
// ----------------------------------------------------------------------------
module stable_sorted_insert_queue_unit #(
  parameter int DEPTH       = ssiq_pkg::DEPTH_DEFAULT,
  parameter int COUNT_WIDTH = ssiq_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      op,
  input  logic [ssiq_pkg::SYMBOL_W-1:0]   symbol,
  input  logic [ssiq_pkg::IN_COUNT_W-1:0] count,
  output logic                            done,
  output logic [ssiq_pkg::SYMBOL_W-1:0]   head_symbol,
  output logic [ssiq_pkg::IN_COUNT_W-1:0] head_count,
  output logic                            head_valid,
  output logic [ssiq_pkg::FILL_W-1:0]     fill,
  output logic                            overflow
);
  import ssiq_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int FW = $clog2(DEPTH + 1);

  logic [CW-1:0]       cnt_m;
  logic [IN_COUNT_W-1:0] head_cnt_ext;
  logic [FW-1:0]       fill_q;
  logic [FW-1:0]       fill_next;
  logic [FILL_W-1:0]   fill_ext;
  logic                full;
  logic                ovf_next;
  logic                accept;
  ssiq_cmd_t           cmd;

  logic                cell_valid [DEPTH];
  logic                cell_gt    [DEPTH];
  logic [SYMBOL_W-1:0] cell_sym   [DEPTH];
  logic [CW-1:0]       cell_cnt   [DEPTH];

  // width adaption between the 32-bit ports and the stored count width
  generate
    if (CW > IN_COUNT_W) begin : g_cnt_wide
      assign cnt_m        = {{(CW - IN_COUNT_W){1'b0}}, count};
      assign head_cnt_ext = cell_cnt[0][IN_COUNT_W-1:0];
    end else if (CW == IN_COUNT_W) begin : g_cnt_same
      assign cnt_m        = count;
      assign head_cnt_ext = cell_cnt[0];
    end else begin : g_cnt_narrow
      assign cnt_m        = count[CW-1:0];
      assign head_cnt_ext = {{(IN_COUNT_W - CW){1'b0}}, cell_cnt[0]};
    end
    if (FW >= FILL_W) begin : g_fill_wide
      assign fill_ext = fill_next[FILL_W-1:0];
    end else begin : g_fill_narrow
      assign fill_ext = {{(FILL_W - FW){1'b0}}, fill_next};
    end
  endgenerate

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (fill_q == FW'(DEPTH));

  always_comb begin
    cmd       = '0;
    fill_next = fill_q;
    ovf_next  = 1'b0;
    if (accept) begin
      case (op)
        OP_INSERT: begin
          if (cnt_m != '0) begin
            if (full) begin
              ovf_next = 1'b1;
            end else begin
              cmd.ins   = 1'b1;
              fill_next = fill_q + 1'b1;
            end
          end
        end
        OP_POP: begin
          if (cell_valid[0]) begin
            cmd.pop   = 1'b1;
            fill_next = fill_q - 1'b1;
          end
        end
        OP_CLEAR: begin
          cmd.clr   = 1'b1;
          fill_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                p_valid;
      logic                p_gt;
      logic [SYMBOL_W-1:0] p_sym;
      logic [CW-1:0]       p_cnt;
      logic                n_valid;
      logic [SYMBOL_W-1:0] n_sym;
      logic [CW-1:0]       n_cnt;

      if (i == 0) begin : g_first
        // head slot sees a kept, non-larger neighbor on its left
        assign p_valid = 1'b1;
        assign p_gt    = 1'b0;
        assign p_sym   = '0;
        assign p_cnt   = '0;
      end else begin : g_mid
        assign p_valid = cell_valid[i-1];
        assign p_gt    = cell_gt[i-1];
        assign p_sym   = cell_sym[i-1];
        assign p_cnt   = cell_cnt[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign n_valid = 1'b0;
        assign n_sym   = '0;
        assign n_cnt   = '0;
      end else begin : g_inner
        assign n_valid = cell_valid[i+1];
        assign n_sym   = cell_sym[i+1];
        assign n_cnt   = cell_cnt[i+1];
      end

      ssiq_cell #(
        .CW(CW)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .new_sym    (symbol),
        .new_cnt    (cnt_m),
        .prev_valid (p_valid),
        .prev_gt    (p_gt),
        .prev_sym   (p_sym),
        .prev_cnt   (p_cnt),
        .next_valid (n_valid),
        .next_sym   (n_sym),
        .next_cnt   (n_cnt),
        .valid      (cell_valid[i]),
        .gt         (cell_gt[i]),
        .sym        (cell_sym[i]),
        .cnt        (cell_cnt[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_q <= '0;
      done   <= 1'b0;
    end else begin
      fill_q <= fill_next;
      done   <= accept;
    end
  end

  always_ff @(posedge clk) begin
    fill       <= fill_ext;
    overflow   <= ovf_next;
    head_valid <= cmd.pop;
    if (cmd.pop) begin
      head_symbol <= cell_sym[0];
      head_count  <= head_cnt_ext;
    end else begin
      head_symbol <= '0;
      head_count  <= '0;
    end
  end

  // zero counts are never stored, so a popped entry is never zero
  a_head_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && head_valid |-> head_count != '0)
    else $error("popped entry has zero count");

  // the head slot holds an entry whenever slot 1 does: no gap at the head slot
  a_packed: assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> cell_valid[0])
    else $error("gap at head slot");

  a_fill_empty: assert property (@(posedge clk) disable iff (rst)
    (fill_q == '0) |-> !cell_valid[0])
    else $error("fill zero with a stored entry");

  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> fill_q == $past(fill_q) - 1'b1)
    else $error("pop did not decrement fill");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf_next |-> full && !cmd.ins)
    else $error("overflow without full queue");

endmodule

/* rtl/ssiq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssiq_cell: one slot of the sorted queue
// Holds one entry, compares it with the broadcast insert count and takes the
// new entry, its left neighbor's entry (insert shift) or its right
// neighbor's entry (pop shift).
// ----------------------------------------------------------------------------
module ssiq_cell #(
  parameter int CW = ssiq_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ssiq_pkg::ssiq_cmd_t           cmd,
  input  logic [ssiq_pkg::SYMBOL_W-1:0] new_sym,
  input  logic [CW-1:0]                 new_cnt,
  input  logic                          prev_valid,
  input  logic                          prev_gt,
  input  logic [ssiq_pkg::SYMBOL_W-1:0] prev_sym,
  input  logic [CW-1:0]                 prev_cnt,
  input  logic                          next_valid,
  input  logic [ssiq_pkg::SYMBOL_W-1:0] next_sym,
  input  logic [CW-1:0]                 next_cnt,
  output logic                          valid,
  output logic                          gt,
  output logic [ssiq_pkg::SYMBOL_W-1:0] sym,
  output logic [CW-1:0]                 cnt
);
  import ssiq_pkg::*;

  logic ins_here;

  // entry is strictly larger: new one goes in front of it (and behind ties)
  assign gt = valid && (cnt > new_cnt);
  // first slot that is larger or empty, with the left slot kept in place
  assign ins_here = (gt || !valid) && prev_valid && !prev_gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clr) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      if (ins_here) begin
        valid <= 1'b1;
      end else if (prev_gt) begin
        valid <= prev_valid;
      end
    end else if (cmd.pop) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (ins_here) begin
        sym <= new_sym;
        cnt <= new_cnt;
      end else if (prev_gt) begin
        sym <= prev_sym;
        cnt <= prev_cnt;
      end
    end else if (cmd.pop) begin
      sym <= next_sym;
      cnt <= next_cnt;
    end
  end

endmodule

/* test/stable_sorted_insert_queue_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_insert_queue_unit_tb: self-checking bench for the sorted queue
// Sends insert, pop, clear and no-op requests with random sender gaps. A
// shadow list of (symbol, count) entries predicts each done strobe, and
// every result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module stable_sorted_insert_queue_unit_tb;
  import ssiq_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;  // unused op code, does nothing
  localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 3;
  localparam int PRINT_LIMIT  = 100;

  typedef struct packed {
    logic [SYMBOL_W-1:0]   sym;
    logic [IN_COUNT_W-1:0] cnt;
  } leaf_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0]   head_symbol;
    logic [IN_COUNT_W-1:0] head_count;
    logic                  head_valid;
    logic [FILL_W-1:0]     fill;
    logic                  overflow;
  } reply_t;

  logic                  clk    = 1'b0;
  logic                  rst    = 1'b1;
  logic                  start  = 1'b0;
  logic [1:0]            op     = OP_INSERT;
  logic [SYMBOL_W-1:0]   symbol = '0;
  logic [IN_COUNT_W-1:0] count  = '0;
  logic                  busy;
  logic                  done;
  logic [SYMBOL_W-1:0]   head_symbol;
  logic [IN_COUNT_W-1:0] head_count;
  logic                  head_valid;
  logic [FILL_W-1:0]     fill;
  logic                  overflow;

  leaf_t  shadow_entries[$];
  reply_t pending_responses[$];
  int     mismatches      = 0;
  int     stall_cycles    = 0;
  int     sender_idle_pct = 0;

  stable_sorted_insert_queue_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .symbol      (symbol),
    .count       (count),
    .done        (done),
    .head_symbol (head_symbol),
    .head_count  (head_count),
    .head_valid  (head_valid),
    .fill        (fill),
    .overflow    (overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    // keep the log short on a badly broken build
    if (mismatches < PRINT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  // applies one request to the shadow list and returns the result it implies
  function automatic reply_t shadow_queue_step(input logic [1:0] o,
                                               input logic [SYMBOL_W-1:0] s,
                                               input logic [IN_COUNT_W-1:0] c);
    reply_t r;
    leaf_t  e;
    int     pos;
    r = '0;
    case (o)
      OP_INSERT: begin
        if (c != '0) begin
          if (shadow_entries.size() >= QUEUE_DEPTH) begin
            r.overflow = 1'b1;
          end else begin
            // after every entry of equal or lower count: ties keep arrival order
            pos = 0;
            while (pos < shadow_entries.size() && shadow_entries[pos].cnt <= c) pos++;
            e.sym = s;
            e.cnt = c;
            shadow_entries.insert(pos, e);
          end
        end
      end
      OP_POP: begin
        if (shadow_entries.size() != 0) begin
          e = shadow_entries.pop_front();
          r.head_symbol = e.sym;
          r.head_count  = e.cnt;
          r.head_valid  = 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_entries.delete();
      end
      default: begin
      end
    endcase
    r.fill = FILL_W'(shadow_entries.size());
    return r;
  endfunction

  // results are checked before the request taken at the same edge is predicted
  always @(posedge clk) begin
    reply_t want;
    if (done) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_responses.pop_front();
        if (head_symbol !== want.head_symbol)
          report_mismatch($sformatf("head_symbol %0h, want %0h", head_symbol, want.head_symbol));
        if (head_count !== want.head_count)
          report_mismatch($sformatf("head_count %0h, want %0h", head_count, want.head_count));
        if (head_valid !== want.head_valid)
          report_mismatch($sformatf("head_valid %0b, want %0b", head_valid, want.head_valid));
        if (fill !== want.fill)
          report_mismatch($sformatf("fill %0d, want %0d", fill, want.fill));
        if (overflow !== want.overflow)
          report_mismatch($sformatf("overflow %0b, want %0b", overflow, want.overflow));
      end
    end
    if (!rst && start && !busy)
      pending_responses.push_back(shadow_queue_step(op, symbol, count));
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || rst) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[%0t] no request or result for %0d cycles", $realtime, STALL_LIMIT);
      $display("** stable_sorted_insert_queue_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // returns at the edge where the request is taken, start still high
  task automatic send_request(input logic [1:0] o, input logic [SYMBOL_W-1:0] s,
                              input logic [IN_COUNT_W-1:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    op     <= o;
    symbol <= s;
    count  <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every predicted result has come back
  task automatic settle_queue();
    start <= 1'b0;
    @(negedge clk);
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IN_COUNT_W-1:0] random_count();
    case ($urandom_range(9))
      0:       return '1;
      1:       return 32'd1;
      2, 3:    return $urandom;
      default: return $urandom_range(12, 1);  // narrow range gives many ties
    endcase
  endfunction

  function automatic logic [SYMBOL_W-1:0] random_symbol();
    return SYMBOL_W'($urandom_range(255));
  endfunction

  task automatic test_directed();
    send_request(OP_POP, 8'h00, 32'h0);                 // pop on empty
    send_request(OP_INSERT, 8'hFF, 32'h0);              // zero count skipped
    send_request(OP_INSERT, 8'h00, 32'h0000_0001);
    send_request(OP_INSERT, 8'hFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 8'hA5, 32'd5);
    send_request(OP_INSERT, 8'h5A, 32'd5);              // tie goes after 8'hA5
    send_request(OP_INSERT, 8'h11, 32'd1);              // tie with head
    send_request(OP_INSERT, 8'h22, 32'h8000_0000);
    send_request(OP_NOP, 8'hFF, 32'hFFFF_FFFF);
    send_request(OP_POP, 8'hFF, 32'hFFFF_FFFF);
    send_request(OP_POP, 8'h00, 32'h0);
    send_request(OP_POP, 8'h00, 32'h0);
    send_request(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF);
    send_request(OP_POP, 8'h00, 32'h0);
    send_request(OP_INSERT, 8'h7E, 32'd3);
    send_request(OP_INSERT, 8'h81, 32'd2);
    send_request(OP_NOP, 8'h00, 32'h0);
    send_request(OP_POP, 8'h00, 32'h0);
    send_request(OP_POP, 8'h00, 32'h0);
    send_request(OP_POP, 8'h00, 32'h0);
    send_request(OP_INSERT, 8'h33, 32'hFFFF_FFFF);
    send_request(OP_CLEAR, 8'h00, 32'h0);
  endtask

  task automatic test_random_mix(input int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 55)
        send_request(OP_INSERT, random_symbol(), random_count());
      else if (sel < 60)
        send_request(OP_INSERT, random_symbol(), '0);
      else if (sel < 90)
        send_request(OP_POP, random_symbol(), $urandom);
      else if (sel < 94)
        send_request(OP_NOP, random_symbol(), $urandom);
      else
        send_request(OP_CLEAR, random_symbol(), $urandom);
    end
  endtask

  task automatic test_fill_to_overflow();
    send_request(OP_CLEAR, 8'h00, 32'h0);
    repeat (QUEUE_DEPTH) send_request(OP_INSERT, random_symbol(), random_count());
    repeat (4) send_request(OP_INSERT, random_symbol(), random_count());
    send_request(OP_INSERT, 8'hFF, 32'h0);   // zero count while full: no overflow
    send_request(OP_NOP, random_symbol(), $urandom);
    repeat (QUEUE_DEPTH + 2) send_request(OP_POP, random_symbol(), $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 27;
    test_directed();
    test_random_mix(120);
    settle_queue();
    sender_idle_pct = 71;
    test_fill_to_overflow();
    sender_idle_pct = 0;
    test_random_mix(120);
    settle_queue();
    if (mismatches == 0) begin
      $display("** stable_sorted_insert_queue_unit: PASSED **");
    end else begin
      $display("** stable_sorted_insert_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
